// ----- rtl/core/cid_pkg.sv -----
// Shared constants and stage record for the pipelined integer divider.
package cid_pkg;

    localparam int unsigned CID_W      = 16;          // word width at full operand size
    localparam int unsigned CID_DW     = 2 * CID_W;   // dividend width at full operand size
    localparam int unsigned CID_BW     = 8;           // word width at byte operand size
    localparam int unsigned CID_STAGES = CID_DW;      // one restoring step per quotient bit

    localparam logic [CID_DW-1:0] CID_MASK_W = {{(CID_DW-CID_W){1'b0}}, {CID_W{1'b1}}};
    localparam logic [CID_DW-1:0] CID_MASK_B = {{(CID_DW-CID_BW){1'b0}}, {CID_BW{1'b1}}};
    localparam logic [CID_DW-1:0] CID_HALF_W = CID_DW'(1) << (CID_W - 1);
    localparam logic [CID_DW-1:0] CID_HALF_B = CID_DW'(1) << (CID_BW - 1);

    typedef enum logic {
        CID_UNSIGNED = 1'b0,
        CID_SIGNED   = 1'b1
    } t_req_type;

    typedef enum logic {
        CID_SIZE_BYTE = 1'b0,
        CID_SIZE_WORD = 1'b1
    } t_op_size;

    // Record handed from cell to cell.
    typedef struct packed {
        logic [CID_W-1:0]  rem;   // partial remainder, below ms unless the divisor is zero
        logic [CID_DW-1:0] rq;    // dividend bits left (high) / quotient bits so far (low)
        logic [CID_W-1:0]  ms;    // divisor magnitude
        logic              nd;    // dividend negative
        logic              nq;    // quotient negative
        logic              sgn;   // signed request
        logic              size;  // word operand size
        logic              zdiv;  // divisor zero
        logic [CID_W-1:0]  zq;    // quotient for a zero divisor
        logic [CID_W-1:0]  zr;    // remainder for a zero divisor
    } t_work;

endpackage

// ----- rtl/core/cid_prep.sv -----
// Entry stage: operand selection, sign-magnitude conversion, zero divisor results.
module cid_prep import cid_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic              i_req_type,
    input  logic              i_op_size,
    input  logic [CID_DW-1:0] i_dividend,
    input  logic [CID_W-1:0]  i_divisor,
    output logic              o_valid,
    output t_work             o_work
);

    logic              r_valid;
    t_work             r_work;
    t_work             n_work;
    logic [CID_DW-1:0] dvd_sel;
    logic [CID_DW-1:0] dmask;
    logic [CID_W-1:0]  dvs_sel;
    logic [CID_W-1:0]  smask;
    logic              nd;
    logic              ns;
    logic              is_signed;
    logic              is_word;

    always_comb begin
        is_signed = (i_req_type == CID_SIGNED);
        is_word   = (i_op_size == CID_SIZE_WORD);
        dmask     = is_word ? {CID_DW{1'b1}} : {{(CID_DW-2*CID_BW){1'b0}}, {(2*CID_BW){1'b1}}};
        smask     = is_word ? {CID_W{1'b1}} : {{(CID_W-CID_BW){1'b0}}, {CID_BW{1'b1}}};
        dvd_sel   = i_dividend & dmask;
        dvs_sel   = i_divisor & smask;
        nd = is_signed & (is_word ? i_dividend[CID_DW-1] : i_dividend[2*CID_BW-1]);
        ns = is_signed & (is_word ? i_divisor[CID_W-1] : i_divisor[CID_BW-1]);

        n_work      = '0;
        n_work.rq   = nd ? ((~dvd_sel + CID_DW'(1)) & dmask) : dvd_sel;
        n_work.ms   = ns ? ((~dvs_sel + CID_W'(1)) & smask) : dvs_sel;
        n_work.nd   = nd;
        n_work.nq   = nd ^ ns;
        n_work.sgn  = is_signed;
        n_work.size = is_word;
        n_work.zdiv = (dvs_sel == '0);
        n_work.zq   = is_word ? ~i_dividend[CID_DW-1:CID_W]
                              : {{(CID_W-CID_BW){1'b0}}, ~i_dividend[2*CID_BW-1:CID_BW]};
        n_work.zr   = is_word ? i_dividend[CID_W-1:0]
                              : {{(CID_W-CID_BW){1'b0}}, i_dividend[CID_BW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ----- rtl/core/cid_cell.sv -----
// One restoring division step: brings in one dividend bit, yields one quotient bit.
module cid_cell import cid_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_work i_work,
    output logic  o_valid,
    output t_work o_work
);

    logic             r_valid;
    t_work            r_work;
    t_work            n_work;
    logic [CID_W:0]   trial;
    logic [CID_W+1:0] diff;
    logic             ge;

    always_comb begin
        trial  = {i_work.rem, i_work.rq[CID_DW-1]};
        diff   = {1'b0, trial} - {2'b00, i_work.ms};
        ge     = ~diff[CID_W+1];
        n_work = i_work;
        n_work.rem = ge ? diff[CID_W-1:0] : trial[CID_W-1:0];
        n_work.rq  = {i_work.rq[CID_DW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

// ----- rtl/core/cid_post.sv -----
// Exit stage: sign fix-up, size truncation, overflow, zero divisor override.
module cid_post import cid_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_work            i_work,
    output logic             o_valid,
    output logic [CID_W-1:0] o_quotient,
    output logic [CID_W-1:0] o_remainder,
    output logic             o_overflow
);

    logic              r_valid;
    logic [CID_W-1:0]  r_quotient;
    logic [CID_W-1:0]  r_remainder;
    logic              r_overflow;
    logic [CID_W-1:0]  n_quotient;
    logic [CID_W-1:0]  n_remainder;
    logic              n_overflow;
    logic [CID_DW-1:0] half;
    logic [CID_DW-1:0] wmask;
    logic [CID_W-1:0]  q_s;
    logic [CID_W-1:0]  r_s;
    logic              ovf_s;
    logic              ovf_u;

    always_comb begin
        half  = i_work.size ? CID_HALF_W : CID_HALF_B;
        wmask = i_work.size ? CID_MASK_W : CID_MASK_B;
        q_s   = i_work.nq ? (~i_work.rq[CID_W-1:0] + CID_W'(1)) : i_work.rq[CID_W-1:0];
        r_s   = i_work.nd ? (~i_work.rem + CID_W'(1)) : i_work.rem;
        ovf_u = (i_work.rq > wmask);
        ovf_s = i_work.nq ? (i_work.rq > half) : (i_work.rq >= half);
        if (i_work.zdiv) begin
            n_quotient  = i_work.zq;
            n_remainder = i_work.zr;
            n_overflow  = 1'b1;
        end else begin
            n_quotient  = q_s & wmask[CID_W-1:0];
            n_remainder = r_s & wmask[CID_W-1:0];
            n_overflow  = i_work.sgn ? ovf_s : ovf_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_overflow  <= n_overflow;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_overflow  = r_overflow;

endmodule

// ----- rtl/core/cpu_integer_divider.sv -----
// Pipelined 32/16 and 16/8 integer divider, signed or unsigned, top level.
//
// Usage:
//   Input channel s_axis: one transfer per division. tdata carries the
//   dividend and divisor, tuser the signed select and the operand size.
//   Output channel m_axis: one transfer per division with quotient and
//   remainder in tdata and the overflow flag in tuser.
// Pipeline: one entry stage, 32 restoring cells and one exit register
//   lie between an input transfer and its result on m_axis. Throughput:
//   one division per cycle unless m_axis stalls; each of the 32 cells
//   retires one quotient bit by an 18-bit subtract, passing its record on.
// Reset: i_rst_n (synchronous, active low) empties every stage; nothing is
//   held across reset.
// Stall: when m_axis_tready is low, the result holds on m_axis and stages
//   behind it keep moving until they close up against it. Input stays
//   ready while any bubble remains in the pipe, so up to 33 divisions can
//   queue behind a stalled result before s_axis_tready falls.
// Special cases: a zero divisor returns the complemented upper dividend
//   half as quotient, the lower half as remainder, overflow set.
module cpu_integer_divider import cid_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] dividend, [47:32] divisor
    input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] op_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] quotient, [31:16] remainder
    output logic [0:0]  m_axis_tuser    // [0] overflow
);

    localparam int unsigned NSTG = CID_STAGES + 2;  // entry + cells + exit

    logic [NSTG-1:0] v;     // stage valid flags, entry at 0, exit at top
    logic [NSTG-1:0] en;    // stage load enables
    t_work           work [CID_STAGES+1];
    logic [CID_W-1:0] quotient;
    logic [CID_W-1:0] remainder;
    logic             overflow;

    // A stage loads when it is empty or its successor loads; bubbles close up.
    always_comb begin
        en[NSTG-1] = ~v[NSTG-1] | m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~v[k] | en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    cid_prep u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en[0]),
        .i_valid    (s_axis_tvalid),
        .i_req_type (s_axis_tuser[0]),
        .i_op_size  (s_axis_tuser[1]),
        .i_dividend (s_axis_tdata[CID_DW-1:0]),
        .i_divisor  (s_axis_tdata[CID_DW+CID_W-1:CID_DW]),
        .o_valid    (v[0]),
        .o_work     (work[0])
    );

    for (genvar g = 0; g < CID_STAGES; g++) begin : g_cell
        cid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g+1]),
            .i_valid (v[g]),
            .i_work  (work[g]),
            .o_valid (v[g+1]),
            .o_work  (work[g+1])
        );
    end

    cid_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en[NSTG-1]),
        .i_valid     (v[NSTG-2]),
        .i_work      (work[CID_STAGES]),
        .o_valid     (v[NSTG-1]),
        .o_quotient  (quotient),
        .o_remainder (remainder),
        .o_overflow  (overflow)
    );

    assign m_axis_tvalid   = v[NSTG-1];
    assign m_axis_tdata    = {remainder, quotient};
    assign m_axis_tuser[0] = overflow;

    // Input is only refused when every stage holds a division.
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&v))
        else $error("input refused while a pipeline stage is empty");

    // For a nonzero divisor, the last cell must leave a remainder below the divisor magnitude.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v[NSTG-2] && !work[CID_STAGES].zdiv) |->
            (work[CID_STAGES].rem < work[CID_STAGES].ms))
        else $error("partial remainder not reduced below divisor");

    // Reset empties the pipe: no result right after it.
    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule
